@@ rtl/core/rgb_matrix_scan_driver_defines.svh @@
// assertion macros for the led matrix scan driver
`ifndef RGB_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define RGB_MATRIX_SCAN_DRIVER_DEFINES_SVH

// checked only outside reset
`define RMSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RMSD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/rmsd_pkg.sv @@
// shared types and constants of the led matrix scan driver
package rmsd_pkg;

   localparam int RMSD_COLUMNS   = 32;
   localparam int RMSD_SCAN_ROWS = 16;
   localparam int ROW_SEL_W      = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [4:0] pixel_row;
      logic [4:0] pixel_column;
      logic [2:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [ROW_SEL_W-1:0] row_select;
      logic [2:0]           upper_rgb;
      logic [2:0]           lower_rgb;
      logic                 shift_pulse;
      logic                 latch_pulse;
      logic                 output_enable;
      logic                 frame_end;
   } rsp_type;

   typedef struct packed {
      logic [ROW_SEL_W-1:0] row_sel;
      logic                 shift;
      logic                 latch;
      logic                 frame_end;
   } scan_ctrl_type;

   typedef struct packed {
      logic       upper_en;
      logic       lower_en;
      logic       clearing;
      logic [2:0] data;
   } wr_ctrl_type;

endpackage

@@ rtl/core/rmsd_chan_if.sv @@
// valid/ready channel carrying one payload per transaction
interface rmsd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmsd_ram.sv @@
// generic single write port ram with registered read
module rmsd_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/rmsd_write.sv @@
// pixel write decode and post-reset clearing pass of the frame buffers
module rmsd_write
   import rmsd_pkg::*;
#(
   parameter int COLUMNS   = RMSD_COLUMNS,
   parameter int SCAN_ROWS = RMSD_SCAN_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_strobe,
   input  req_type                              wr_req,
   output wr_ctrl_type                          wr_ctrl,
   output logic [$clog2(SCAN_ROWS*COLUMNS)-1:0] wr_addr
);
   localparam int DEPTH  = SCAN_ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              col_ok;
   logic              is_upper;
   logic              is_lower;
   logic [ADDR_W-1:0] pix_addr;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // rows below SCAN_ROWS go to the upper half, the next SCAN_ROWS to the lower
   always_comb begin
      col_ok   = 32'(wr_req.pixel_column) < COLUMNS;
      is_upper = 32'(wr_req.pixel_row) < SCAN_ROWS;
      is_lower = !is_upper && (32'(wr_req.pixel_row) < 2 * SCAN_ROWS);
      if (is_upper) begin
         pix_addr = ADDR_W'(32'(wr_req.pixel_row) * COLUMNS + 32'(wr_req.pixel_column));
      end else begin
         pix_addr = ADDR_W'((32'(wr_req.pixel_row) - SCAN_ROWS) * COLUMNS
                            + 32'(wr_req.pixel_column));
      end
   end

   always_comb begin
      wr_ctrl.clearing = clearing_ff;
      if (clearing_ff) begin
         wr_ctrl.upper_en = 1'b1;
         wr_ctrl.lower_en = 1'b1;
         wr_ctrl.data     = '0;
         wr_addr          = clr_addr_ff;
      end else begin
         wr_ctrl.upper_en = wr_strobe && col_ok && is_upper;
         wr_ctrl.lower_en = wr_strobe && col_ok && is_lower;
         wr_ctrl.data     = wr_req.pixel_color;
         wr_addr          = pix_addr;
      end
   end
endmodule

@@ rtl/core/rmsd_scan.sv @@
// scan position sequencer: shift items, latch item and frame end item
module rmsd_scan
   import rmsd_pkg::*;
#(
   parameter int COLUMNS   = RMSD_COLUMNS,
   parameter int SCAN_ROWS = RMSD_SCAN_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tick,
   output logic [$clog2(SCAN_ROWS*COLUMNS)-1:0] rd_addr,
   output scan_ctrl_type                        scan_ctrl
);
   localparam int ADDR_W = $clog2(SCAN_ROWS * COLUMNS);
   localparam int ROW_W  = $clog2(SCAN_ROWS);
   localparam int SUB_W  = $clog2(COLUMNS + 1);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCAN_ROWS - 1);
   localparam logic [SUB_W-1:0] LAST_COL  = SUB_W'(COLUMNS - 1);
   localparam logic [SUB_W-1:0] SUB_LATCH = SUB_W'(COLUMNS);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [SUB_W-1:0] sub_ff, sub_in;
   logic             at_end_ff, at_end_in;
   logic [ROW_W-1:0] rsel;
   logic [SUB_W-1:0] csel;

   always_comb begin
      row_in    = row_ff;
      sub_in    = sub_ff;
      at_end_in = at_end_ff;
      if (tick) begin
         if (at_end_ff) begin
            at_end_in = 1'b0;
            row_in    = '0;
            sub_in    = '0;
         end else if (sub_ff != SUB_LATCH) begin
            sub_in = sub_ff + 1'b1;
         end else begin
            sub_in = '0;
            if (row_ff == LAST_ROW) begin
               at_end_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         sub_ff    <= '0;
         at_end_ff <= 1'b0;
      end else begin
         row_ff    <= row_in;
         sub_ff    <= sub_in;
         at_end_ff <= at_end_in;
      end
   end

   // latch items keep the last column of the current row pair shown, frame end items that of the last row pair
   always_comb begin
      rsel = at_end_ff ? LAST_ROW : row_ff;
      csel = (at_end_ff || sub_ff == SUB_LATCH) ? LAST_COL : sub_ff;
      rd_addr = ADDR_W'(32'(rsel) * COLUMNS + 32'(csel));
      scan_ctrl.row_sel   = ROW_SEL_W'(rsel);
      scan_ctrl.shift     = !at_end_ff && (sub_ff != SUB_LATCH);
      scan_ctrl.latch     = !at_end_ff && (sub_ff == SUB_LATCH);
      scan_ctrl.frame_end = at_end_ff;
   end
endmodule

@@ rtl/core/rgb_matrix_scan_driver.sv @@
// a scan tick transaction gives its result after the frame buffer read and the output register, later if rsp_if stalls
// throughput: one transaction per cycle, writes and ticks alike, while rsp_if.ready is high
// the frame buffer read port and one output register stage set the latency
// after reset a clearing pass over all SCAN_ROWS*COLUMNS addresses (512 by default) zeroes the
// frame buffers; no transaction is accepted until it ends
`include "rgb_matrix_scan_driver_defines.svh"

module rgb_matrix_scan_driver
   import rmsd_pkg::*;
#(
   parameter int COLUMNS   = RMSD_COLUMNS,
   parameter int SCAN_ROWS = RMSD_SCAN_ROWS
) (
   input logic              clock,
   input logic              reset,
   rmsd_chan_if.sink        req_if,
   rmsd_chan_if.source      rsp_if
);
   localparam int DEPTH  = SCAN_ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ROW_SEL_W-1:0] LAST_SEL = ROW_SEL_W'(SCAN_ROWS - 1);

   req_type           req;
   logic              req_fire;
   logic              wr_strobe;
   logic              tick;
   wr_ctrl_type       wr_ctrl;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   scan_ctrl_type     scan_ctrl;
   logic [2:0]        upper_rd;
   logic [2:0]        lower_rd;
   logic              advance;

   logic              s1_valid_ff, s1_valid_in;
   scan_ctrl_type     s1_ctrl_ff, s1_ctrl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   assign req       = req_if.data;
   assign req_fire  = req_if.valid && req_if.ready;
   assign wr_strobe = req_fire && (req.operation == OP_WRITE);
   assign tick      = req_fire && (req.operation == OP_TICK);

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !wr_ctrl.clearing && (!s1_valid_ff || advance);

   rmsd_write #(
      .COLUMNS   (COLUMNS),
      .SCAN_ROWS (SCAN_ROWS)
   ) u_write (
      .clock     (clock),
      .reset     (reset),
      .wr_strobe (wr_strobe),
      .wr_req    (req),
      .wr_ctrl   (wr_ctrl),
      .wr_addr   (wr_addr)
   );

   rmsd_scan #(
      .COLUMNS   (COLUMNS),
      .SCAN_ROWS (SCAN_ROWS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .rd_addr   (rd_addr),
      .scan_ctrl (scan_ctrl)
   );

   rmsd_ram #(
      .WIDTH (3),
      .DEPTH (DEPTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (wr_ctrl.upper_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ctrl.data),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (upper_rd)
   );

   rmsd_ram #(
      .WIDTH (3),
      .DEPTH (DEPTH)
   ) u_lower_ram (
      .clock   (clock),
      .wr_en   (wr_ctrl.lower_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ctrl.data),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (lower_rd)
   );

   // read stage holds with the ram output until the result register frees up
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ctrl_in  = s1_ctrl_ff;
      if (tick) begin
         s1_valid_in = 1'b1;
         s1_ctrl_in  = scan_ctrl;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.row_select    = s1_ctrl_ff.row_sel;
         rsp_data_in.upper_rgb     = upper_rd;
         rsp_data_in.lower_rgb     = lower_rd;
         rsp_data_in.shift_pulse   = s1_ctrl_ff.shift;
         rsp_data_in.latch_pulse   = s1_ctrl_ff.latch;
         rsp_data_in.output_enable = s1_ctrl_ff.frame_end;
         rsp_data_in.frame_end     = s1_ctrl_ff.frame_end;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ctrl_ff  <= s1_ctrl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   `RMSD_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_if.ready, "transaction accepted during clearing pass")
   `RMSD_ASSERT(a_stage_hold, s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ctrl_ff), "read stage lost a stalled result")
   `RMSD_ASSERT(a_frame_end_pins, rsp_valid_ff && rsp_data_ff.frame_end |-> rsp_data_ff.output_enable && !rsp_data_ff.shift_pulse && !rsp_data_ff.latch_pulse && rsp_data_ff.row_select == LAST_SEL, "frame end item with wrong pin state")
endmodule

@@ test/rgb_matrix_scan_driver_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the led matrix scan driver, predicting every pin state
module rgb_matrix_scan_driver_test;
   import rmsd_pkg::*;

   localparam int ROW_ITEMS    = RMSD_COLUMNS + 1;
   localparam int FRAME_ITEMS  = RMSD_SCAN_ROWS * ROW_ITEMS;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      req_type txn;
      logic    fixed;
      rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   rmsd_chan_if #(.payload_type(req_type)) req_if ();
   rmsd_chan_if #(.payload_type(rsp_type)) rsp_if ();

   rgb_matrix_scan_driver u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [2:0]   upper_pixels [RMSD_SCAN_ROWS][RMSD_COLUMNS];
   logic [2:0]   lower_pixels [RMSD_SCAN_ROWS][RMSD_COLUMNS];
   int           scan_index;
   rsp_type      pending_pin_states [$];
   stim_row_type directed_rows [$];
   logic         offer_fixed;
   rsp_type      offer_rsp;
   int           error_count = 0;
   int           cycle_count = 0;
   bit           sender_idles = 1'b1;
   bit           receiver_idles = 1'b1;
   bit           hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic rsp_type next_pin_state();
      rsp_type s;
      int      pair;
      int      sub;
      s = '0;
      if (scan_index >= FRAME_ITEMS) begin
         s.row_select    = ROW_SEL_W'(RMSD_SCAN_ROWS - 1);
         s.upper_rgb     = upper_pixels[RMSD_SCAN_ROWS-1][RMSD_COLUMNS-1];
         s.lower_rgb     = lower_pixels[RMSD_SCAN_ROWS-1][RMSD_COLUMNS-1];
         s.output_enable = 1'b1;
         s.frame_end     = 1'b1;
         scan_index      = 0;
      end else begin
         pair = scan_index / ROW_ITEMS;
         sub  = scan_index % ROW_ITEMS;
         s.row_select = ROW_SEL_W'(pair);
         if (sub < RMSD_COLUMNS) begin
            s.upper_rgb   = upper_pixels[pair][sub];
            s.lower_rgb   = lower_pixels[pair][sub];
            s.shift_pulse = 1'b1;
         end else begin
            s.upper_rgb   = upper_pixels[pair][RMSD_COLUMNS-1];
            s.lower_rgb   = lower_pixels[pair][RMSD_COLUMNS-1];
            s.latch_pulse = 1'b1;
         end
         scan_index++;
      end
      return s;
   endfunction

   task automatic store_pixel(req_type t);
      int r;
      int c;
      r = t.pixel_row;
      c = t.pixel_column;
      if (c < RMSD_COLUMNS) begin
         if (r < RMSD_SCAN_ROWS)
            upper_pixels[r][c] = t.pixel_color;
         else if (r < 2 * RMSD_SCAN_ROWS)
            lower_pixels[r-RMSD_SCAN_ROWS][c] = t.pixel_color;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      req_type txn;
      rsp_type pred;
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            txn = req_if.data;
            if (txn.operation == OP_TICK) begin
               pred = next_pin_state();
               pending_pin_states.push_back(offer_fixed ? offer_rsp : pred);
            end else begin
               store_pixel(txn);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_pin_states.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = pending_pin_states.pop_front();
               if (got.row_select !== want.row_select)
                  report_mismatch("row_select", got.row_select, want.row_select);
               if (got.upper_rgb !== want.upper_rgb)
                  report_mismatch("upper_rgb", got.upper_rgb, want.upper_rgb);
               if (got.lower_rgb !== want.lower_rgb)
                  report_mismatch("lower_rgb", got.lower_rgb, want.lower_rgb);
               if (got.shift_pulse !== want.shift_pulse)
                  report_mismatch("shift_pulse", got.shift_pulse, want.shift_pulse);
               if (got.latch_pulse !== want.latch_pulse)
                  report_mismatch("latch_pulse", got.latch_pulse, want.latch_pulse);
               if (got.output_enable !== want.output_enable)
                  report_mismatch("output_enable", got.output_enable, want.output_enable);
               if (got.frame_end !== want.frame_end)
                  report_mismatch("frame_end", got.frame_end, want.frame_end);
            end
         end
      end
   end

   function automatic int idle_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60)
         return 0;
      else if (p < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic stim_row_type pixel_write(logic [4:0] r, logic [4:0] c,
                                                logic [2:0] colour);
      stim_row_type s;
      s = '0;
      s.txn.operation    = OP_WRITE;
      s.txn.pixel_row    = r;
      s.txn.pixel_column = c;
      s.txn.pixel_color  = colour;
      return s;
   endfunction

   // tick on row pair zero while columns are shifted in
   function automatic stim_row_type first_pair_tick(logic [2:0] up, logic [2:0] lo);
      stim_row_type s;
      s = '0;
      s.txn.operation   = OP_TICK;
      s.fixed           = 1'b1;
      s.rsp.upper_rgb   = up;
      s.rsp.lower_rgb   = lo;
      s.rsp.shift_pulse = 1'b1;
      return s;
   endfunction

   function automatic req_type random_txn();
      req_type t;
      t.operation = ($urandom_range(0, 99) < 85) ? OP_TICK : OP_WRITE;
      if ($urandom_range(0, 3) == 0)
         t.pixel_row = $urandom_range(0, 1) ? 5'd15 : 5'd31;
      else
         t.pixel_row = 5'($urandom_range(0, 31));
      t.pixel_column = ($urandom_range(0, 3) == 0) ? 5'd31 : 5'($urandom_range(0, 31));
      t.pixel_color  = 3'($urandom_range(0, 7));
      return t;
   endfunction

   task automatic send_item(req_type t, logic fixed, rsp_type r);
      req_if.valid <= 1'b1;
      req_if.data  <= t;
      offer_fixed  <= fixed;
      offer_rsp    <= r;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic sender_gap();
      int n;
      n = sender_idles ? idle_length() : 0;
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      int n;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         n = receiver_idles ? idle_length() : 0;
         if (n > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      offer_fixed  <= 1'b0;
      offer_rsp    <= '0;
      foreach (upper_pixels[r, c]) begin
         upper_pixels[r][c] = 3'd0;
         lower_pixels[r][c] = 3'd0;
      end
      scan_index = 0;

      directed_rows = '{
         first_pair_tick(3'd0, 3'd0),
         pixel_write(5'd0, 5'd1, 3'd7),
         pixel_write(5'd31, 5'd1, 3'd7),
         first_pair_tick(3'd7, 3'd0),
         pixel_write(5'd0, 5'd2, 3'd4),
         pixel_write(5'd16, 5'd2, 3'd1),
         first_pair_tick(3'd4, 3'd1),
         pixel_write(5'd0, 5'd3, 3'd2),
         pixel_write(5'd16, 5'd3, 3'd2),
         first_pair_tick(3'd2, 3'd2),
         pixel_write(5'd0, 5'd4, 3'd7),
         pixel_write(5'd0, 5'd4, 3'd0),
         first_pair_tick(3'd0, 3'd0),
         pixel_write(5'd15, 5'd31, 3'd5),
         pixel_write(5'd31, 5'd31, 3'd6),
         pixel_write(5'd15, 5'd0, 3'd3),
         pixel_write(5'd16, 5'd0, 3'd7),
         pixel_write(5'd0, 5'd31, 3'd1),
         pixel_write(5'd16, 5'd31, 3'd4),
         first_pair_tick(3'd0, 3'd0),
         pixel_write(5'd0, 5'd6, 3'd6),
         pixel_write(5'd16, 5'd6, 3'd5),
         first_pair_tick(3'd6, 3'd5)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].txn, directed_rows[i].fixed, directed_rows[i].rsp);
         sender_gap();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) begin
            sender_idles   = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
         end
         // long receiver stall while transactions keep coming
         if (i == 300) begin
            sender_idles = 1'b0;
            hold_request = 1'b1;
         end
         if (i == 600) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (pending_pin_states.size() != 0) @(posedge clock);
         end
         send_item(random_txn(), 1'b0, '0);
         sender_gap();
      end

      req_if.valid <= 1'b0;
      while (pending_pin_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_pin_states.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rmsd_pkg.sv
rtl/core/rmsd_chan_if.sv
rtl/core/rmsd_ram.sv
rtl/core/rmsd_write.sv
rtl/core/rmsd_scan.sv
rtl/core/rgb_matrix_scan_driver.sv
test/rgb_matrix_scan_driver_test.sv
